FILE: sv/mspr_pkg.sv
// ---------------------------------------------------------------------------
// mspr_pkg
// Shared types and constants of the motor speed ramp and pwm timer unit.
// ---------------------------------------------------------------------------
package mspr_pkg;

  localparam int unsigned TimerBitsDef = 16;

  localparam int unsigned SpeedW   = 14;
  localparam int unsigned CmdW     = 15;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned StepW    = 14;
  localparam int unsigned ClockW   = 32;
  localparam int unsigned FullHzW  = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned QuoW     = 32;

  localparam logic [SpeedW-1:0]   SpeedFull  = SpeedW'(10000);
  localparam logic [30:0]         RoundHalf  = 31'(5000);
  localparam logic [PeriodW-1:0]  PeriodRst  = PeriodW'(10);
  localparam logic [StepW-1:0]    StepRst    = StepW'(25);
  localparam logic [ClockW-1:0]   ClockRst   = ClockW'(84000000);
  localparam logic [FullHzW-1:0]  FullHzRst  = FullHzW'(25000);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAMP_PERIOD = 2'd0,
    CFG_RAMP_STEP   = 2'd1,
    CFG_TIMER_CLOCK = 2'd2,
    CFG_FULL_SPEED  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOTOR,
    ST_FREQ_WAIT,
    ST_PSC,
    ST_PSC_WAIT,
    ST_MUL,
    ST_RLD,
    ST_RLD_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              reverse;
    logic [SpeedW-1:0] speed;
  } motor_state_t;

endpackage

FILE: sv/mspr_ramp.sv
// ---------------------------------------------------------------------------
// mspr_ramp
// Command decode, direction change and one ramp step for a single motor.
// ---------------------------------------------------------------------------
module mspr_ramp
  import mspr_pkg::*;
(
  input  motor_state_t      cur_i,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic              step_en_i,
  input  logic [StepW-1:0]  ramp_step_i,
  output motor_state_t      nxt_o
);

  logic              req_rev;
  logic [15:0]       mag_raw;
  logic [SpeedW-1:0] mag;
  logic              dir1;
  logic [SpeedW-1:0] tgt;
  logic [SpeedW-1:0] ramped;
  logic [SpeedW-1:0] stepped;

  always_comb begin
    req_rev = cmd_i[CmdW-1];
    mag_raw = req_rev ? (16'h8000 - {1'b0, cmd_i}) : {1'b0, cmd_i};
    mag     = (mag_raw > 16'(SpeedFull)) ? SpeedFull : mag_raw[SpeedW-1:0];

    dir1 = (req_rev != cur_i.reverse && cur_i.speed == '0) ? req_rev : cur_i.reverse;
    tgt  = (req_rev != dir1) ? '0 : mag;

    if (ramp_step_i == '0) begin
      ramped = tgt;
    end else if (cur_i.speed < tgt) begin
      ramped = ((tgt - cur_i.speed) > ramp_step_i) ? cur_i.speed + ramp_step_i : tgt;
    end else if (cur_i.speed > tgt) begin
      ramped = ((cur_i.speed - tgt) > ramp_step_i) ? cur_i.speed - ramp_step_i : tgt;
    end else begin
      ramped = cur_i.speed;
    end

    stepped = step_en_i ? ramped : cur_i.speed;

    nxt_o.speed   = stepped;
    nxt_o.reverse = (step_en_i && req_rev != dir1 && stepped == '0) ? req_rev : dir1;
  end

endmodule

FILE: sv/mspr_div.sv
// ---------------------------------------------------------------------------
// mspr_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module mspr_div
  import mspr_pkg::*;
#(
  parameter int unsigned DivisorW = TimerBitsDef + 18
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [QuoW-1:0]     dividend_i,
  input  logic [DivisorW-1:0] divisor_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [QuoW-1:0]     quotient_o
);

  localparam int unsigned CmpW = (DivisorW > QuoW + 1) ? DivisorW : QuoW + 1;
  localparam int unsigned CntW = $clog2(QuoW);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [QuoW-1:0]     rem_q, rem_d;
  logic [QuoW-1:0]     quo_q, quo_d;
  logic [DivisorW-1:0] dvs_q, dvs_d;

  logic [QuoW:0]   trial;
  logic [CmpW-1:0] diff;
  logic            ge;

  always_comb begin
    trial  = {rem_q, quo_q[QuoW-1]};
    ge     = CmpW'(trial) >= CmpW'(dvs_q);
    diff   = CmpW'(trial) - CmpW'(dvs_q);
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '1;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[QuoW-1:0] : trial[QuoW-1:0];
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: sv/motor_speed_ramp_pwm_unit.sv
// ---------------------------------------------------------------------------
// motor_speed_ramp_pwm_unit
// Two-motor speed ramp with pwm prescaler, reload and compare calculation.
//
//   channel   dir  fields
//   s_axis    in   left_speed, right_speed, now_ms
//   m_axis    out  reverse, running, prescaler, reload, compare per motor
//   cfg       in   ramp_period_ms, ramp_step, timer_clock_hz, full_speed_hz
//
// the shared divider runs for each running motor, for the prescaler and then,
// unless the prescaler is out of range, for the reload; a stopped motor skips
// it. the frequency comes from a reciprocal multiply. no clearing pass after
// reset. a new item is taken while a finished result still waits; the next
// result waits for it.
// ---------------------------------------------------------------------------
module motor_speed_ramp_pwm_unit
  import mspr_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TimerBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // left_speed[14:0], right_speed[29:15], now_ms[61:30], zero fill
  input  logic [63:0]            s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // left_reverse, right_reverse, left_running, right_running, then per motor
  // left prescaler, reload, compare, right prescaler, reload, compare, zero fill
  output logic [((4+6*TIMER_BITS+7)/8)*8-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned DivW  = TIMER_BITS + 18;
  localparam int unsigned PW    = TIMER_BITS + 1;
  localparam int unsigned OutW  = 4 + 6 * TIMER_BITS;
  localparam int unsigned OutPW = ((OutW + 7) / 8) * 8;
  localparam logic [QuoW:0] MaxExt = ((QuoW+1)'(1) << TIMER_BITS) - (QuoW+1)'(1);
  localparam logic [TIMER_BITS-1:0] TimerMax = '1;
  localparam int unsigned FreqShift = 37;
  localparam logic [27:0] FreqRecip = 28'd219902326;

  logic [PeriodW-1:0] period_q;
  logic [StepW-1:0]   step_q;
  logic [ClockW-1:0]  clock_q;
  logic [FullHzW-1:0] fullhz_q;

  motor_state_t left_q, right_q, left_nxt, right_nxt;
  logic [TimeW-1:0] last_q;
  logic             step_en;
  logic [TimeW-1:0] now_in;
  logic             in_acc;

  state_e state_q, state_d;
  logic   mot_q, mot_d;
  logic [FullHzW-1:0] freq_q, freq_d;
  logic [QuoW-1:0]    p_q, p_d;
  logic [DivW-1:0]    prod_q, prod_d;

  logic [TIMER_BITS-1:0] psc_q [2];
  logic [TIMER_BITS-1:0] arr_q [2];
  logic [TIMER_BITS-1:0] cmp_q [2];
  logic                  res_we;
  logic [TIMER_BITS-1:0] res_psc, res_arr, res_cmp;
  logic [PW-1:0]         arr_inc, p_inc;

  logic               out_valid_q, out_valid_d, out_load;
  logic [OutPW-1:0]   out_data_q;

  logic               div_start, div_busy, div_done;
  logic [QuoW-1:0]    div_dividend, div_quo;
  logic [DivW-1:0]    div_divisor;
  logic [SpeedW-1:0]  speed_sel;
  logic [30:0]        fprod;
  logic [54:0]        fmul;
  logic [FullHzW-1:0] fquo;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodRst;
      step_q   <= StepRst;
      clock_q  <= ClockRst;
      fullhz_q <= FullHzRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RAMP_PERIOD: period_q <= cfg_data_i[PeriodW-1:0];
        CFG_RAMP_STEP:   step_q   <= cfg_data_i[StepW-1:0];
        CFG_TIMER_CLOCK: clock_q  <= cfg_data_i[ClockW-1:0];
        CFG_FULL_SPEED:  fullhz_q <= cfg_data_i[FullHzW-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign now_in  = s_axis_tdata[61:30];
  assign step_en = (now_in - last_q) >= TimeW'(period_q);

  mspr_ramp u_ramp_left (
    .cur_i       (left_q),
    .cmd_i       (s_axis_tdata[14:0]),
    .step_en_i   (step_en),
    .ramp_step_i (step_q),
    .nxt_o       (left_nxt)
  );

  mspr_ramp u_ramp_right (
    .cur_i       (right_q),
    .cmd_i       (s_axis_tdata[29:15]),
    .step_en_i   (step_en),
    .ramp_step_i (step_q),
    .nxt_o       (right_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
      last_q  <= '0;
    end else if (in_acc) begin
      left_q  <= left_nxt;
      right_q <= right_nxt;
      if (step_en) begin
        last_q <= now_in;
      end
    end
  end

  mspr_div #(
    .DivisorW (DivW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    mot_d        = mot_q;
    freq_d       = freq_q;
    p_d          = p_q;
    prod_d       = prod_q;
    div_start    = 1'b0;
    div_dividend = clock_q;
    div_divisor  = prod_q;
    res_we       = 1'b0;
    res_psc      = TimerMax;
    res_arr      = TimerMax;
    out_load     = 1'b0;
    speed_sel    = mot_q ? right_q.speed : left_q.speed;
    fprod        = 31'(speed_sel) * 31'(fullhz_q) + RoundHalf;
    p_inc        = PW'({1'b0, p_q}) + PW'(1);
    // divide by 16 then by 625 through a reciprocal multiply
    fmul         = 55'(prod_q[26:0]) * 55'(FreqRecip);
    fquo         = fmul[FreqShift +: FullHzW];

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          mot_d   = 1'b0;
          state_d = ST_MOTOR;
        end
      end
      ST_MOTOR: begin
        if (speed_sel == '0) begin
          res_we  = 1'b1;
          res_psc = '0;
          res_arr = '0;
          mot_d   = 1'b1;
          state_d = mot_q ? ST_OUT : ST_MOTOR;
        end else begin
          prod_d  = DivW'(fprod[30:4]);
          state_d = ST_FREQ_WAIT;
        end
      end
      ST_FREQ_WAIT: begin
        freq_d  = (fquo == '0) ? FullHzW'(1) : fquo;
        state_d = ST_PSC;
      end
      ST_PSC: begin
        div_start   = 1'b1;
        div_divisor = DivW'({freq_q, {TIMER_BITS{1'b0}}}) + DivW'(freq_q);
        state_d     = ST_PSC_WAIT;
      end
      ST_PSC_WAIT: begin
        if (div_done) begin
          p_d     = div_quo;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if ({1'b0, p_q} > MaxExt) begin
          res_we  = 1'b1;
          mot_d   = 1'b1;
          state_d = mot_q ? ST_OUT : ST_MOTOR;
        end else begin
          prod_d  = DivW'(p_inc) * DivW'(freq_q);
          state_d = ST_RLD;
        end
      end
      ST_RLD: begin
        div_start = 1'b1;
        state_d   = ST_RLD_WAIT;
      end
      ST_RLD_WAIT: begin
        if (div_done) begin
          res_we = 1'b1;
          if (div_quo != '0) begin
            res_psc = p_q[TIMER_BITS-1:0];
            res_arr = TIMER_BITS'(div_quo - QuoW'(1));
          end
          mot_d   = 1'b1;
          state_d = mot_q ? ST_OUT : ST_MOTOR;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    arr_inc = PW'(res_arr) + PW'(1);
    res_cmp = arr_inc[PW-1:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mot_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mot_q   <= mot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q <= freq_d;
    p_q    <= p_d;
    prod_q <= prod_d;
    if (res_we) begin
      psc_q[mot_q] <= res_psc;
      arr_q[mot_q] <= res_arr;
      cmp_q[mot_q] <= res_cmp;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OutPW'({cmp_q[1], arr_q[1], psc_q[1], cmp_q[0], arr_q[0], psc_q[0],
                            right_q.speed != '0, left_q.speed != '0,
                            right_q.reverse, left_q.reverse});
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_div_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_start && div_busy))
    else $error("divider started while busy");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again before item finished");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("result shown outside output step");
`endif

endmodule
